// ----- src/bcr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bcr_pkg;

  // Obstacle kinds as they arrive on the input beat.
  typedef enum logic [2:0] {
    KIND_HCUSHION   = 3'd0,
    KIND_VCUSHION   = 3'd1,
    KIND_HOLE       = 3'd2,
    KIND_STILL_BALL = 3'd3,
    KIND_ROLL_BALL  = 3'd4
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_DRAG      = 1'b0,
    CFG_SPEED_EPS = 1'b1
  } cfg_idx_e;

  localparam logic [30:0] DRAG_RESET      = 31'd9830400;
  localparam logic [30:0] SPEED_EPS_RESET = 31'd655;

  typedef struct packed {
    logic [2:0]         obstacle_kind;
    logic signed [31:0] a_pos_x;
    logic signed [31:0] a_pos_y;
    logic signed [31:0] a_vel_x;
    logic signed [31:0] a_vel_y;
    logic signed [31:0] a_acc_x;
    logic signed [31:0] a_acc_y;
    logic signed [31:0] b_pos_x;
    logic signed [31:0] b_pos_y;
    logic signed [31:0] b_vel_x;
    logic signed [31:0] b_vel_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] new_a_vel_x;
    logic signed [31:0] new_a_vel_y;
    logic signed [31:0] new_a_acc_x;
    logic signed [31:0] new_a_acc_y;
    logic signed [31:0] new_b_vel_x;
    logic signed [31:0] new_b_vel_y;
    logic signed [31:0] new_b_acc_x;
    logic signed [31:0] new_b_acc_y;
    logic               ball_removed;
  } out_beat_t;

  // State of the digit-by-digit square root.
  typedef struct packed {
    logic [63:0] s;
    logic [63:0] r;
  } sqrt_t;

  // State of the restoring divider: partial remainder and quotient so far.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] q;
  } div_t;

  // Saturate a 36-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
    logic signed [31:0] y;
    if (!x[35] && (x[34:31] != 4'h0)) begin
      y = 32'sh7FFF_FFFF;
    end else if (x[35] && (x[34:31] != 4'hF)) begin
      y = 32'sh8000_0000;
    end else begin
      y = x[31:0];
    end
    return y;
  endfunction

  // Negate with saturation of the most negative value.
  function automatic logic signed [31:0] neg_sat32(input logic signed [31:0] x);
    logic signed [31:0] y;
    if (x == 32'sh8000_0000) begin
      y = 32'sh7FFF_FFFF;
    end else begin
      y = -x;
    end
    return y;
  endfunction

  // Divide by 2^30, rounding to nearest with ties away from zero.
  function automatic logic signed [35:0] rnd30(input logic signed [65:0] x);
    logic [65:0] m;
    logic [35:0] r;
    m = x[65] ? 66'(-x) : 66'(x);
    m = m + (66'd1 << 29);
    r = m[65:30];
    return x[65] ? -$signed(r) : $signed(r);
  endfunction

  // One step of the integer square root, for result bit i.
  function automatic sqrt_t sqrt_step(input sqrt_t x, input int unsigned i);
    logic [63:0] bit_v;
    logic [63:0] trial;
    sqrt_t       y;
    bit_v = 64'd1 << (2 * i);
    trial = x.r + bit_v;
    if (x.s >= trial) begin
      y.s = x.s - trial;
      y.r = (x.r >> 1) + bit_v;
    end else begin
      y.s = x.s;
      y.r = x.r >> 1;
    end
    return y;
  endfunction

  // One step of restoring division: shift in one numerator bit.
  function automatic div_t div_step(input div_t x, input logic [31:0] den, input logic nb);
    logic [32:0] sh;
    div_t        y;
    sh = {x.rem, nb};
    if (sh >= {1'b0, den}) begin
      y.rem = 32'(sh - {1'b0, den});
      y.q   = {x.q[30:0], 1'b1};
    end else begin
      y.rem = sh[31:0];
      y.q   = {x.q[30:0], 1'b0};
    end
    return y;
  endfunction

endpackage

`default_nettype wire

// ----- src/bcr_stream_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Valid/ready channel carrying one beat of payload.
interface bcr_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/ball_collision_response_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Collision response for a moving ball against a cushion, a hole or a second
// ball, in signed Q16.16 with saturation. The core is a fixed pipeline of 143
// register stages that accepts one beat per cycle unless a result waits untaken.
// The depth is set by the four chains of one-bit-per-stage
// arithmetic for a ball contact: the 32-step square root for the normal length,
// the 31-step divide for the unit normal, the 32-step square roots for both
// speeds and the 32-step divides for the drag accelerations. Every kind of
// obstacle takes the same path, so results leave in order. When the output
// beat is not taken the whole pipeline holds. The drag and stop-speed registers
// are read in the middle of the pipeline, so write them only while no beat is
// in flight.
module ball_collision_response_core
  import bcr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [30:0] cfg_wdata_i,
  bcr_stream_if.sink   in_if,
  bcr_stream_if.source out_if
);

  localparam int SqrtSteps = 32;
  localparam int NdivSteps = 31;
  localparam int AdivSteps = 32;
  localparam int NumStages = 16 + 2 * SqrtSteps + NdivSteps + AdivSteps;

  typedef struct packed {
    logic      is_ball;
    out_beat_t byp;
  } side_t;

  typedef struct packed {
    side_t              side;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic               negx;
    logic               negy;
    logic [32:0]        mx;
    logic [32:0]        my;
  } ent_t;

  typedef struct packed {
    side_t              side;
    logic signed [32:0] vx;
    logic signed [32:0] vy;
    logic               negx;
    logic               negy;
    logic               zero;
    logic [30:0]        nmx;
    logic [30:0]        nmy;
  } geo_t;

  typedef struct packed {
    geo_t        g;
    logic [31:0] len;
    div_t        dx;
    div_t        dy;
  } nd_t;

  typedef struct packed {
    side_t             side;
    logic [3:0]        neg;
    logic [3:0][62:0]  prod;
  } vc_t;

  typedef struct packed {
    side_t            side;
    logic [3:0]       neg;
    logic [3:0]       take;
    logic [3:0]       ovf;
    logic [3:0][62:0] mp;
    logic [1:0][31:0] sp;
  } ac_t;

  // Configuration registers.
  logic [30:0] drag_q;
  logic [30:0] eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drag_q <= DRAG_RESET;
      eps_q  <= SPEED_EPS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DRAG:      drag_q <= cfg_wdata_i;
        CFG_SPEED_EPS: eps_q  <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // Pipeline advance and valid bits.
  logic                 adv;
  logic [NumStages-1:0] vld_q;

  assign adv         = !vld_q[NumStages-1] || out_if.ready;
  assign in_if.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], in_if.valid};
    end
  end

  // Entry: cushion and hole results, relative position and velocity.
  in_beat_t           ib;
  ent_t               e_d, e_q;
  logic signed [32:0] rx, ry;

  assign ib = in_if.data;

  always_comb begin
    e_d.side.is_ball              = 1'b0;
    e_d.side.byp.new_a_vel_x      = ib.a_vel_x;
    e_d.side.byp.new_a_vel_y      = ib.a_vel_y;
    e_d.side.byp.new_a_acc_x      = ib.a_acc_x;
    e_d.side.byp.new_a_acc_y      = ib.a_acc_y;
    e_d.side.byp.new_b_vel_x      = ib.b_vel_x;
    e_d.side.byp.new_b_vel_y      = ib.b_vel_y;
    e_d.side.byp.new_b_acc_x      = '0;
    e_d.side.byp.new_b_acc_y      = '0;
    e_d.side.byp.ball_removed     = 1'b0;
    unique case (ib.obstacle_kind)
      KIND_HCUSHION: begin
        e_d.side.byp.new_a_vel_y = neg_sat32(ib.a_vel_y);
        e_d.side.byp.new_a_acc_y = neg_sat32(ib.a_acc_y);
      end
      KIND_VCUSHION: begin
        e_d.side.byp.new_a_vel_x = neg_sat32(ib.a_vel_x);
        e_d.side.byp.new_a_acc_x = neg_sat32(ib.a_acc_x);
      end
      KIND_HOLE: begin
        e_d.side.byp.new_a_vel_x  = '0;
        e_d.side.byp.new_a_vel_y  = '0;
        e_d.side.byp.new_a_acc_x  = '0;
        e_d.side.byp.new_a_acc_y  = '0;
        e_d.side.byp.ball_removed = 1'b1;
      end
      KIND_STILL_BALL: begin
        e_d.side.is_ball         = 1'b1;
        e_d.side.byp.new_b_vel_x = '0;
        e_d.side.byp.new_b_vel_y = '0;
      end
      KIND_ROLL_BALL: begin
        e_d.side.is_ball = 1'b1;
      end
      default: ;
    endcase
    rx = {ib.a_pos_x[31], ib.a_pos_x} - {ib.b_pos_x[31], ib.b_pos_x};
    ry = {ib.a_pos_y[31], ib.a_pos_y} - {ib.b_pos_y[31], ib.b_pos_y};
    e_d.vx = {ib.a_vel_x[31], ib.a_vel_x}
           - {e_d.side.byp.new_b_vel_x[31], e_d.side.byp.new_b_vel_x};
    e_d.vy = {ib.a_vel_y[31], ib.a_vel_y}
           - {e_d.side.byp.new_b_vel_y[31], e_d.side.byp.new_b_vel_y};
    e_d.negx = rx[32];
    e_d.negy = ry[32];
    e_d.mx   = rx[32] ? 33'(-rx) : 33'(rx);
    e_d.my   = ry[32] ? 33'(-ry) : 33'(ry);
  end

  always_ff @(posedge clk_i) begin
    if (adv) e_q <= e_d;
  end

  // Leading one of the larger magnitude.
  logic [32:0] mmax;
  logic [5:0]  lp_d, lp_q;
  logic        lz_d, lz_q;
  ent_t        l_q;

  always_comb begin
    mmax = (e_q.mx > e_q.my) ? e_q.mx : e_q.my;
    lz_d = (mmax == '0);
    lp_d = '0;
    for (int i = 0; i < 33; i++) begin
      if (mmax[i]) lp_d = 6'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      l_q  <= e_q;
      lp_q <= lp_d;
      lz_q <= lz_d;
    end
  end

  // Normalize so the larger magnitude lies in [2^30, 2^31).
  geo_t       nm_d, nm_q;
  logic [1:0] shr;
  logic [4:0] shl;

  always_comb begin
    nm_d.side = l_q.side;
    nm_d.vx   = l_q.vx;
    nm_d.vy   = l_q.vy;
    nm_d.negx = l_q.negx;
    nm_d.negy = l_q.negy;
    nm_d.zero = lz_q;
    shr       = '0;
    shl       = '0;
    if (lp_q >= 6'd30) begin
      shr      = 2'(lp_q - 6'd30);
      nm_d.nmx = 31'(l_q.mx >> shr);
      nm_d.nmy = 31'(l_q.my >> shr);
    end else begin
      shl      = 5'(6'd30 - lp_q);
      nm_d.nmx = 31'(l_q.mx << shl);
      nm_d.nmy = 31'(l_q.my << shl);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) nm_q <= nm_d;
  end

  // Squares of the normalized components, then their sum.
  geo_t        sq_q, ss_c_q;
  logic [61:0] sqx_q, sqy_q;
  sqrt_t       ss_r_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_q   <= nm_q;
      sqx_q  <= nm_q.nmx * nm_q.nmx;
      sqy_q  <= nm_q.nmy * nm_q.nmy;
      ss_c_q <= sq_q;
      ss_r_q <= '{s: 64'(sqx_q) + 64'(sqy_q), r: '0};
    end
  end

  // Square root of the normal length, one result bit per stage.
  geo_t  s1c_q [SqrtSteps];
  sqrt_t s1r_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt_len
    geo_t  c_in;
    sqrt_t r_in;
    if (k == 0) begin : g_head
      assign c_in = ss_c_q;
      assign r_in = ss_r_q;
    end else begin : g_tail
      assign c_in = s1c_q[k-1];
      assign r_in = s1r_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s1c_q[k] <= c_in;
        s1r_q[k] <= sqrt_step(r_in, 32'(SqrtSteps - 1 - k));
      end
    end
  end

  // Unit normal components: magnitude * 2^30 / length, one bit per stage.
  nd_t nd_q [NdivSteps];

  for (genvar k = 0; k < NdivSteps; k++) begin : g_ndiv
    nd_t  n_in;
    logic nbx, nby;
    if (k == 0) begin : g_head
      always_comb begin
        n_in.g      = s1c_q[SqrtSteps-1];
        n_in.len    = s1r_q[SqrtSteps-1].r[31:0];
        n_in.dx.rem = {2'b00, s1c_q[SqrtSteps-1].nmx[30:1]};
        n_in.dx.q   = '0;
        n_in.dy.rem = {2'b00, s1c_q[SqrtSteps-1].nmy[30:1]};
        n_in.dy.q   = '0;
        nbx         = s1c_q[SqrtSteps-1].nmx[0];
        nby         = s1c_q[SqrtSteps-1].nmy[0];
      end
    end else begin : g_tail
      assign n_in = nd_q[k-1];
      assign nbx  = 1'b0;
      assign nby  = 1'b0;
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        nd_q[k].g   <= n_in.g;
        nd_q[k].len <= n_in.len;
        nd_q[k].dx  <= div_step(n_in.dx, n_in.len, nbx);
        nd_q[k].dy  <= div_step(n_in.dy, n_in.len, nby);
      end
    end
  end

  // Signed normal; zero when the centres coincide.
  nd_t                nl;
  side_t              nrm_side_q;
  logic signed [32:0] nrm_vx_q, nrm_vy_q;
  logic signed [31:0] nx_d, ny_d, nx_q, ny_q;
  logic signed [31:0] qxs, qys;

  assign nl  = nd_q[NdivSteps-1];
  assign qxs = $signed({1'b0, nl.dx.q[30:0]});
  assign qys = $signed({1'b0, nl.dy.q[30:0]});

  always_comb begin
    nx_d = nl.g.negx ? -qxs : qxs;
    ny_d = nl.g.negy ? -qys : qys;
    if (nl.g.zero) begin
      nx_d = '0;
      ny_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      nrm_side_q <= nl.g.side;
      nrm_vx_q   <= nl.g.vx;
      nrm_vy_q   <= nl.g.vy;
      nx_q       <= nx_d;
      ny_q       <= ny_d;
    end
  end

  // Normal velocity and the exchanged velocity along the normal.
  side_t              dot_side_q, vn_side_q, prd_side_q, rnd_side_q;
  logic signed [31:0] dot_nx_q, dot_ny_q, vn_nx_q, vn_ny_q;
  logic signed [64:0] px_q, py_q;
  logic signed [35:0] vn_q;
  logic signed [67:0] ex_q, ey_q;
  logic signed [35:0] dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dot_side_q <= nrm_side_q;
      dot_nx_q   <= nx_q;
      dot_ny_q   <= ny_q;
      px_q       <= nrm_vx_q * nx_q;
      py_q       <= nrm_vy_q * ny_q;
      vn_side_q  <= dot_side_q;
      vn_nx_q    <= dot_nx_q;
      vn_ny_q    <= dot_ny_q;
      vn_q       <= rnd30(66'(px_q) + 66'(py_q));
      prd_side_q <= vn_side_q;
      ex_q       <= vn_q * vn_nx_q;
      ey_q       <= vn_q * vn_ny_q;
      rnd_side_q <= prd_side_q;
      dx_q       <= rnd30(66'(ex_q));
      dy_q       <= rnd30(66'(ey_q));
    end
  end

  // New velocities of both balls; other obstacles keep their bypass values.
  side_t nv_d, nv_q;

  always_comb begin
    nv_d = rnd_side_q;
    if (rnd_side_q.is_ball) begin
      nv_d.byp.new_a_vel_x = sat32(36'(rnd_side_q.byp.new_a_vel_x) - dx_q);
      nv_d.byp.new_a_vel_y = sat32(36'(rnd_side_q.byp.new_a_vel_y) - dy_q);
      nv_d.byp.new_b_vel_x = sat32(36'(rnd_side_q.byp.new_b_vel_x) + dx_q);
      nv_d.byp.new_b_vel_y = sat32(36'(rnd_side_q.byp.new_b_vel_y) + dy_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) nv_q <= nv_d;
  end

  // Velocity squares and drag products; components a_x, a_y, b_x, b_y.
  logic signed [31:0] vel [4];
  logic [31:0]        vmag [4];
  vc_t                sq2_d, sq2_q, sum2_c_q;
  logic [3:0][63:0]   vsq_d, vsq_q;
  sqrt_t [1:0]        sum2_r_q;

  always_comb begin
    vel[0]     = nv_q.byp.new_a_vel_x;
    vel[1]     = nv_q.byp.new_a_vel_y;
    vel[2]     = nv_q.byp.new_b_vel_x;
    vel[3]     = nv_q.byp.new_b_vel_y;
    sq2_d.side = nv_q;
    for (int c = 0; c < 4; c++) begin
      vmag[c]         = vel[c][31] ? 32'(-vel[c]) : 32'(vel[c]);
      vsq_d[c]        = vmag[c] * vmag[c];
      sq2_d.prod[c]   = vmag[c] * drag_q;
      sq2_d.neg[c]    = ~vel[c][31];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq2_q       <= sq2_d;
      vsq_q       <= vsq_d;
      sum2_c_q    <= sq2_q;
      sum2_r_q[0] <= '{s: vsq_q[0] + vsq_q[1], r: '0};
      sum2_r_q[1] <= '{s: vsq_q[2] + vsq_q[3], r: '0};
    end
  end

  // Speeds of both balls, one result bit per stage.
  vc_t         s2c_q [SqrtSteps];
  sqrt_t [1:0] s2r_q [SqrtSteps];

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt_spd
    vc_t         c_in;
    sqrt_t [1:0] r_in;
    if (k == 0) begin : g_head
      assign c_in = sum2_c_q;
      assign r_in = sum2_r_q;
    end else begin : g_tail
      assign c_in = s2c_q[k-1];
      assign r_in = s2r_q[k-1];
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        s2c_q[k]    <= c_in;
        s2r_q[k][0] <= sqrt_step(r_in[0], 32'(SqrtSteps - 1 - k));
        s2r_q[k][1] <= sqrt_step(r_in[1], 32'(SqrtSteps - 1 - k));
      end
    end
  end

  // Drag divide setup: threshold test, rounding offset, overflow test.
  ac_t p1_d, p1_q, p2_d, p2_q;
  vc_t sl;

  assign sl = s2c_q[SqrtSteps-1];

  always_comb begin
    p1_d.side  = sl.side;
    p1_d.neg   = sl.neg;
    p1_d.ovf   = '0;
    p1_d.sp[0] = s2r_q[SqrtSteps-1][0].r[31:0];
    p1_d.sp[1] = s2r_q[SqrtSteps-1][1].r[31:0];
    for (int c = 0; c < 4; c++) begin
      p1_d.take[c] = p1_d.sp[c >> 1] > {1'b0, eps_q};
      p1_d.mp[c]   = sl.prod[c] + 63'(p1_d.sp[c >> 1] >> 1);
    end
  end

  always_comb begin
    p2_d = p1_q;
    for (int c = 0; c < 4; c++) begin
      p2_d.ovf[c] = {1'b0, p1_q.mp[c][62:32]} >= p1_q.sp[c >> 1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
    end
  end

  // Drag divides, one quotient bit per stage.
  ac_t        adc_q [AdivSteps];
  div_t [3:0] adv_q [AdivSteps];

  for (genvar k = 0; k < AdivSteps; k++) begin : g_adiv
    ac_t        c_in;
    div_t [3:0] d_in;
    div_t [3:0] d_out;
    if (k == 0) begin : g_head
      assign c_in = p2_q;
      always_comb begin
        for (int c = 0; c < 4; c++) begin
          d_in[c].rem = {1'b0, p2_q.mp[c][62:32]};
          d_in[c].q   = '0;
        end
      end
    end else begin : g_tail
      assign c_in = adc_q[k-1];
      assign d_in = adv_q[k-1];
    end
    always_comb begin
      for (int c = 0; c < 4; c++) begin
        d_out[c] = div_step(d_in[c], c_in.sp[c >> 1], c_in.mp[c][AdivSteps-1-k]);
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        adc_q[k] <= c_in;
        adv_q[k] <= d_out;
      end
    end
  end

  // Final accelerations and the output register.
  ac_t                al;
  div_t [3:0]         dl;
  logic signed [31:0] acc [4];
  out_beat_t          out_d, out_q;

  assign al = adc_q[AdivSteps-1];
  assign dl = adv_q[AdivSteps-1];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (!al.take[c]) begin
        acc[c] = al.sp[c >> 1][31] ? 32'sh7FFF_FFFF : $signed(al.sp[c >> 1]);
      end else if (al.neg[c]) begin
        acc[c] = (al.ovf[c] || (dl[c].q > 32'h8000_0000)) ? 32'sh8000_0000
                                                          : -$signed(dl[c].q);
      end else begin
        acc[c] = (al.ovf[c] || dl[c].q[31]) ? 32'sh7FFF_FFFF : $signed(dl[c].q);
      end
    end
    out_d = al.side.byp;
    if (al.side.is_ball) begin
      out_d.new_a_acc_x = acc[0];
      out_d.new_a_acc_y = acc[1];
      out_d.new_b_acc_x = acc[2];
      out_d.new_b_acc_y = acc[3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= out_d;
  end

  assign out_if.valid = vld_q[NumStages-1];
  assign out_if.data  = out_q;

endmodule

`default_nettype wire

// ----- tb/sv/ball_collision_response_core_test.sv -----
`timescale 1ns / 1ps

module ball_collision_response_core_test;
  import bcr_pkg::*;

  localparam int LATENCY = 143;
  localparam longint CYCLE_LIMIT = 400000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [30:0] cfg_wdata_i;

  bcr_stream_if #(.payload_t(in_beat_t))  in_if ();
  bcr_stream_if #(.payload_t(out_beat_t)) out_if ();

  ball_collision_response_core dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if(in_if.sink),
    .out_if(out_if.source)
  );

  // Copy of the drag and stop-threshold registers used for prediction.
  longint drag_q16;
  longint stop_speed_q16;

  in_beat_t  pending_collisions[$];
  out_beat_t expected_motion[$];
  int        error_count;
  longint    cycle_count;
  bit        quiet_phase;
  bit        stimulus_done;
  // Set at a rising edge at which the input beat was taken.
  bit        in_fire;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint round_shift(longint x, int k);
    longint unsigned m;
    m = (x < 0) ? -x : x;
    m = (m + (64'd1 << (k - 1))) >> k;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned m;
    m = (num < 0) ? -num : num;
    m = (m + den / 2) / den;
    return (num < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned root;
    longint unsigned b;
    root = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= root + b) begin
        s -= root + b;
        root = (root >> 1) + b;
      end else begin
        root >>= 1;
      end
      b >>= 2;
    end
    return root;
  endfunction

  // Drag deceleration opposing the velocity, or the speed itself when stopped.
  function automatic void drag_accel(longint vx, longint vy, output longint ax,
                                     output longint ay);
    longint unsigned spd;
    spd = int_sqrt(longint'(vx * vx) + longint'(vy * vy));
    if (spd > stop_speed_q16) begin
      ax = clamp32(round_div(-(vx * drag_q16), spd));
      ay = clamp32(round_div(-(vy * drag_q16), spd));
    end else begin
      ax = clamp32(spd);
      ay = clamp32(spd);
    end
  endfunction

  function automatic out_beat_t collision_response(in_beat_t c);
    longint avx, avy, aax, aay, bvx, bvy, bax, bay;
    longint rx, ry, nx, ny, vx, vy, vn, dx, dy;
    longint unsigned mx, my, len;
    out_beat_t r;
    avx = c.a_vel_x; avy = c.a_vel_y; aax = c.a_acc_x; aay = c.a_acc_y;
    bvx = c.b_vel_x; bvy = c.b_vel_y; bax = 0; bay = 0;
    r.ball_removed = 1'b0;
    case (c.obstacle_kind)
      KIND_HCUSHION: begin
        avy = clamp32(-avy);
        aay = clamp32(-aay);
      end
      KIND_VCUSHION: begin
        avx = clamp32(-avx);
        aax = clamp32(-aax);
      end
      KIND_HOLE: begin
        r.ball_removed = 1'b1;
        avx = 0; avy = 0; aax = 0; aay = 0;
      end
      KIND_STILL_BALL, KIND_ROLL_BALL: begin
        rx = longint'(c.a_pos_x) - longint'(c.b_pos_x);
        ry = longint'(c.a_pos_y) - longint'(c.b_pos_y);
        mx = (rx < 0) ? -rx : rx;
        my = (ry < 0) ? -ry : ry;
        nx = 0;
        ny = 0;
        if (c.obstacle_kind == KIND_STILL_BALL) begin
          bvx = 0;
          bvy = 0;
        end
        // Normalize the larger offset into [2^30, 2^31) before the square root.
        if (mx != 0 || my != 0) begin
          while ((mx > my ? mx : my) < (64'd1 << 30)) begin
            mx <<= 1;
            my <<= 1;
          end
          while ((mx > my ? mx : my) >= (64'd1 << 31)) begin
            mx >>= 1;
            my >>= 1;
          end
          len = int_sqrt(mx * mx + my * my);
          nx = (mx << 30) / len;
          ny = (my << 30) / len;
          if (rx < 0) nx = -nx;
          if (ry < 0) ny = -ny;
        end
        vx = avx - bvx;
        vy = avy - bvy;
        vn = round_shift(vx * nx + vy * ny, 30);
        dx = round_shift(vn * nx, 30);
        dy = round_shift(vn * ny, 30);
        avx = clamp32(avx - dx);
        avy = clamp32(avy - dy);
        bvx = clamp32(bvx + dx);
        bvy = clamp32(bvy + dy);
        drag_accel(avx, avy, aax, aay);
        drag_accel(bvx, bvy, bax, bay);
      end
      default: ;
    endcase
    r.new_a_vel_x = avx[31:0]; r.new_a_vel_y = avy[31:0];
    r.new_a_acc_x = aax[31:0]; r.new_a_acc_y = aay[31:0];
    r.new_b_vel_x = bvx[31:0]; r.new_b_vel_y = bvy[31:0];
    r.new_b_acc_x = bax[31:0]; r.new_b_acc_y = bay[31:0];
    return r;
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(0, 200)) - 100);
      3, 4: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_beat_t random_collision();
    in_beat_t c;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) c.obstacle_kind = (roll < 40) ? KIND_ROLL_BALL : KIND_STILL_BALL;
    else c.obstacle_kind = 3'($urandom_range(0, 7));
    c.a_pos_x = pick_value(); c.a_pos_y = pick_value();
    c.a_vel_x = pick_value(); c.a_vel_y = pick_value();
    c.a_acc_x = pick_value(); c.a_acc_y = pick_value();
    c.b_pos_x = pick_value(); c.b_pos_y = pick_value();
    c.b_vel_x = pick_value(); c.b_vel_y = pick_value();
    // Sometimes put the balls on top of each other or nearly so.
    if ($urandom_range(0, 9) == 0) begin
      c.b_pos_x = c.a_pos_x;
      c.b_pos_y = c.a_pos_y;
    end else if ($urandom_range(0, 9) == 0) begin
      c.b_pos_x = c.a_pos_x + 32'($urandom_range(0, 4)) - 2;
      c.b_pos_y = c.a_pos_y + 32'($urandom_range(0, 4)) - 2;
    end
    return c;
  endfunction

  function automatic in_beat_t make_collision(kind_e k, logic [31:0] v);
    in_beat_t c;
    c.obstacle_kind = k;
    c.a_pos_x = v; c.a_pos_y = ~v; c.a_vel_x = v; c.a_vel_y = ~v;
    c.a_acc_x = v; c.a_acc_y = ~v; c.b_pos_x = ~v; c.b_pos_y = v;
    c.b_vel_x = ~v; c.b_vel_y = v;
    return c;
  endfunction

  task automatic write_register(cfg_idx_e idx, logic [30:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DRAG) drag_q16 = value;
    else stop_speed_q16 = value;
  endtask

  // Wait until every expected result has come back and the pipeline is empty.
  task automatic drain_pipeline();
    wait (pending_collisions.size() == 0 && !in_if.valid);
    wait (expected_motion.size() == 0);
    repeat (LATENCY + 10) @(negedge clk_i);
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) pending_collisions.push_back(random_collision());
  endtask

  // Driver: offers the oldest pending item, idling at random.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.data  <= '0;
    end else if (in_if.valid && !in_fire) begin
      // Hold the beat until it is taken.
    end else begin
      if (pending_collisions.size() != 0 && (quiet_phase || $urandom_range(0, 99) >= 17))
          begin
        in_if.valid <= 1'b1;
        in_if.data  <= pending_collisions.pop_front();
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= quiet_phase || ($urandom_range(0, 99) >= 17);
  end

  // Monitor: predicts on accepted inputs and checks accepted outputs.
  always @(posedge clk_i) begin
    out_beat_t want;
    out_beat_t got;
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      in_fire     <= in_if.valid && in_if.ready;
      if (in_if.valid && in_if.ready)
        expected_motion.push_back(collision_response(in_if.data));
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (expected_motion.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          error_count++;
        end else begin
          want = expected_motion.pop_front();
          if (want !== got) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            $display("  a_vel %h %h / %h %h", want.new_a_vel_x, want.new_a_vel_y,
                     got.new_a_vel_x, got.new_a_vel_y);
            $display("  a_acc %h %h / %h %h", want.new_a_acc_x, want.new_a_acc_y,
                     got.new_a_acc_x, got.new_a_acc_y);
            $display("  b_vel %h %h / %h %h", want.new_b_vel_x, want.new_b_vel_y,
                     got.new_b_vel_x, got.new_b_vel_y);
            $display("  b_acc %h %h / %h %h removed %b / %b", want.new_b_acc_x,
                     want.new_b_acc_y, got.new_b_acc_x, got.new_b_acc_y,
                     want.ball_removed, got.ball_removed);
            error_count++;
          end
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    in_beat_t c;
    error_count    = 0;
    cycle_count    = 0;
    quiet_phase    = 1'b0;
    stimulus_done  = 1'b0;
    in_fire        = 1'b0;
    drag_q16       = DRAG_RESET;
    stop_speed_q16 = SPEED_EPS_RESET;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_DRAG;
    cfg_wdata_i    = '0;
    rst_ni         = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every kind, field extremes, coincident centres, unused kinds.
    for (int k = 0; k < 8; k++) begin
      pending_collisions.push_back(make_collision(kind_e'(k), 32'h8000_0000));
      pending_collisions.push_back(make_collision(kind_e'(k), 32'h7FFF_FFFF));
    end
    c = make_collision(KIND_ROLL_BALL, 32'h0001_0000);
    c.b_pos_x = c.a_pos_x; c.b_pos_y = c.a_pos_y;
    pending_collisions.push_back(c);
    c.obstacle_kind = KIND_STILL_BALL;
    pending_collisions.push_back(c);
    c = make_collision(KIND_STILL_BALL, 32'h0);
    c.a_vel_x = 32'd100; c.a_vel_y = 0; c.b_pos_x = 32'hFFF0_0000; c.b_pos_y = 0;
    pending_collisions.push_back(c);
    c.obstacle_kind = KIND_ROLL_BALL; c.b_vel_x = 32'd100; c.b_vel_y = 0;
    pending_collisions.push_back(c);
    c = make_collision(KIND_ROLL_BALL, 32'h0);
    c.a_pos_x = 32'h7FFF_FFFF; c.b_pos_x = 32'h8000_0000;
    c.a_vel_x = 32'h8000_0000; c.b_vel_x = 32'h7FFF_FFFF;
    pending_collisions.push_back(c);
    run_phase(100);
    drain_pipeline();

    // Extreme register settings, with a stretch of no idling.
    write_register(CFG_DRAG, 31'h7FFF_FFFF);
    write_register(CFG_SPEED_EPS, 31'h0);
    quiet_phase = 1'b1;
    run_phase(100);
    drain_pipeline();
    quiet_phase = 1'b0;

    write_register(CFG_DRAG, 31'h0);
    write_register(CFG_SPEED_EPS, 31'h7FFF_FFFF);
    run_phase(100);
    drain_pipeline();

    write_register(CFG_DRAG, 31'($urandom));
    write_register(CFG_SPEED_EPS, 31'($urandom_range(0, 32'h0010_0000)));
    run_phase(130);
    wait (pending_collisions.size() == 0 && !in_if.valid);
    wait (expected_motion.size() == 0);
    repeat (LATENCY + 20) @(negedge clk_i);

    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
